// File: hw/rtl/cs_pkg.sv
// cs_pkg: shared types and character constants for the comment stripper
// no dependencies; imported by cs_scan, cs_resq, comment_stripper and tb

package cs_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_LINE       = 3'd1,
		MODE_BLOCK      = 3'd2,
		MODE_BLOCK_STAR = 3'd3,
		MODE_STRING     = 3'd4,
		MODE_STRING_ESC = 3'd5
	} scan_mode_t;

	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_STAR      = 8'h2a;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;

	// one output word
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} res_t;

	// results produced by one input word, packed from r0 up
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} scan_res_t;

endpackage

// File: hw/rtl/comment_stripper.sv
// comment_stripper: top level, strips c-style comments from a byte stream
// an accepted input word is held in the input register; its results are then registered in the result queue
// throughput: one input word per cycle; any held input word waits, and stalls the input,
//   while the four-entry result queue has fewer than two free slots
// reset: arst_n clears the input valid flag, scanner state, queue pointers and queue count
// depends on cs_pkg, cs_scan and cs_resq

module comment_stripper import cs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] byte_valid
	output logic       m_tlast    // end_of_text
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic      advance;
	logic      room;
	scan_res_t scan_res;
	res_t      head;

	// the held word moves into the queue when there is room for two results
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// scanner: decides what each word produces and updates the mode
	cs_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (scan_res)
	);

	// result queue decouples the output side from the scanner
	cs_resq u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance),
		.push_res   (scan_res),
		.room       (room),
		.head_valid (m_tvalid),
		.head       (head),
		.pop        (m_tready)
	);

	assign m_tdata = head.data;
	assign m_tuser = head.valid;
	assign m_tlast = head.last;

	a_tready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	a_advance_drains: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !(s_tvalid && s_tready) |=> !valid_s1)
		else $error("input register not released");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input word lost");

endmodule

// File: hw/rtl/cs_scan.sv
// cs_scan: scanner state and per-word decode of comments and strings
// depends on cs_pkg

module cs_scan import cs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output scan_res_t  res
);

	scan_mode_t mode_q, mode_d;
	logic       slash_q, slash_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			slash_q <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			slash_q <= slash_d;
		end
	end

	always_comb begin
		logic       e0_v, e1_v;
		logic [7:0] e0_b, e1_b;
		scan_mode_t m;
		logic       s;
		e0_v = 1'b0;
		e1_v = 1'b0;
		e0_b = 8'h00;
		e1_b = 8'h00;
		m    = mode_q;
		s    = 1'b0;
		res  = '0;

		if (slash_q) begin
			if (in_byte == CH_SLASH) begin
				m = MODE_LINE;
			end else if (in_byte == CH_STAR) begin
				m = MODE_BLOCK;
			end else begin
				// held slash goes out first, then this byte as plain text
				e0_v = 1'b1;
				e0_b = CH_SLASH;
				e1_v = 1'b1;
				e1_b = in_byte;
				if (in_byte == CH_QUOTE)
					m = MODE_STRING;
			end
		end else begin
			case (mode_q)
				MODE_LINE: begin
					if (in_byte == CH_NEWLINE) begin
						e0_v = 1'b1;
						e0_b = in_byte;
						m    = MODE_NORMAL;
					end
				end
				MODE_BLOCK: begin
					if (in_last) begin
						e0_v = 1'b1;
						e0_b = in_byte;
					end else if (in_byte == CH_STAR) begin
						m = MODE_BLOCK_STAR;
					end else if (in_byte == CH_NEWLINE) begin
						e0_v = 1'b1;
						e0_b = in_byte;
					end
				end
				MODE_BLOCK_STAR: begin
					if (in_byte == CH_SLASH) begin
						m = MODE_NORMAL;
					end else if (in_last) begin
						e0_v = 1'b1;
						e0_b = in_byte;
					end else if (in_byte != CH_STAR) begin
						e0_v = (in_byte == CH_NEWLINE);
						e0_b = in_byte;
						m    = MODE_BLOCK;
					end
				end
				MODE_STRING: begin
					e0_v = 1'b1;
					e0_b = in_byte;
					if (in_byte == CH_QUOTE)
						m = MODE_NORMAL;
					else if (in_byte == CH_BACKSLASH && !in_last)
						m = MODE_STRING_ESC;
				end
				MODE_STRING_ESC: begin
					e0_v = 1'b1;
					e0_b = in_byte;
					m    = MODE_STRING;
				end
				default: begin
					m = MODE_NORMAL;
					if (in_byte == CH_SLASH && !in_last) begin
						s = 1'b1;
					end else begin
						e0_v = 1'b1;
						e0_b = in_byte;
						if (in_byte == CH_QUOTE)
							m = MODE_STRING;
					end
				end
			endcase
		end

		// e1 only ever comes with e0
		if (e0_v) begin
			res.r0 = '{data: e0_b, valid: 1'b1, last: 1'b0};
			res.r1 = '{data: e1_b, valid: e1_v, last: 1'b0};
			res.count = e1_v ? 2'd2 : 2'd1;
		end

		if (in_last) begin
			if (!e0_v) begin
				res.count = 2'd1;
				res.r0    = '{data: 8'h00, valid: 1'b0, last: 1'b1};
			end else if (e1_v) begin
				res.r1.last = 1'b1;
			end else begin
				res.r0.last = 1'b1;
			end
			m = MODE_NORMAL;
			s = 1'b0;
		end

		mode_d  = m;
		slash_d = s;
	end

	a_slash_in_normal: assert property (@(posedge clk) disable iff (!arst_n)
		slash_q |-> mode_q == MODE_NORMAL)
		else $error("slash held outside normal text");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_last |=> mode_q == MODE_NORMAL && !slash_q)
		else $error("state not cleared after end of text");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_last |-> res.count != 2'd0)
		else $error("end of text without a result");

endmodule

// File: hw/rtl/cs_resq.sv
// cs_resq: four-entry result queue, up to two pushes and one pop per cycle
// depends on cs_pkg

module cs_resq import cs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  scan_res_t push_res,
	output logic      room,
	output logic      head_valid,
	output res_t      head,
	input  logic      pop
);

	res_t       entry_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic [1:0] n_push;
	logic       do_pop;

	assign n_push     = push ? push_res.count : 2'd0;
	assign head_valid = (count_q != 3'd0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;
	// two free slots needed for the worst case
	assign room       = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			entry_q[wr_ptr_q] <= push_res.r0;
		if (n_push == 2'd2)
			entry_q[wr_ptr_q + 2'd1] <= push_res.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, n_push} - {2'b00, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		n_push != 2'd0 |-> room)
		else $error("push into full queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		!push && !do_pop |=> $stable(count_q))
		else $error("count moved without traffic");

endmodule

// File: dv/tb.sv
// tb: self-checking bench for comment_stripper, directed texts first and then random ones
// an in-bench scanner predicts every output word; depends on cs_pkg and the rtl

module tb;
	import cs_pkg::*;

	// tracks the scanner state, predicts output words and checks them in order
	class strip_scoreboard;
		scan_mode_t mode;
		bit         slash_held;
		res_t       expected_words[$];
		res_t       step_words[$];
		int         errors;

		function new();
			mode       = MODE_NORMAL;
			slash_held = 1'b0;
			errors     = 0;
		endfunction

		function void put_byte(logic [7:0] b);
			res_t r;
			r.data  = b;
			r.valid = 1'b1;
			r.last  = 1'b0;
			step_words.push_back(r);
		endfunction

		// plain text: a slash is held back unless it ends the text
		function void plain_text(logic [7:0] b, logic fin);
			if (b == CH_SLASH && !fin) begin
				slash_held = 1'b1;
			end else begin
				put_byte(b);
				if (b == CH_QUOTE)
					mode = MODE_STRING;
			end
		endfunction

		function void note_input(logic [7:0] b, logic fin);
			res_t r;
			step_words.delete();
			if (slash_held) begin
				slash_held = 1'b0;
				if (b == CH_SLASH) begin
					mode = MODE_LINE;
				end else if (b == CH_STAR) begin
					mode = MODE_BLOCK;
				end else begin
					put_byte(CH_SLASH);
					plain_text(b, fin);
				end
			end else begin
				case (mode)
					MODE_LINE: begin
						if (b == CH_NEWLINE) begin
							put_byte(b);
							mode = MODE_NORMAL;
						end
					end
					MODE_BLOCK: begin
						if (fin)
							put_byte(b);
						else if (b == CH_STAR)
							mode = MODE_BLOCK_STAR;
						else if (b == CH_NEWLINE)
							put_byte(b);
					end
					MODE_BLOCK_STAR: begin
						if (b == CH_SLASH) begin
							mode = MODE_NORMAL;
						end else if (fin) begin
							put_byte(b);
						end else if (b != CH_STAR) begin
							// a repeated star keeps the chance of a close
							if (b == CH_NEWLINE)
								put_byte(b);
							mode = MODE_BLOCK;
						end
					end
					MODE_STRING: begin
						put_byte(b);
						if (b == CH_QUOTE)
							mode = MODE_NORMAL;
						else if (b == CH_BACKSLASH && !fin)
							mode = MODE_STRING_ESC;
					end
					MODE_STRING_ESC: begin
						put_byte(b);
						mode = MODE_STRING;
					end
					default: begin
						mode = MODE_NORMAL;
						plain_text(b, fin);
					end
				endcase
			end
			if (fin) begin
				// an empty marker word when the final byte yields nothing
				if (step_words.size() == 0) begin
					r = '0;
					step_words.push_back(r);
				end
				r      = step_words.pop_back();
				r.last = 1'b1;
				step_words.push_back(r);
				mode       = MODE_NORMAL;
				slash_held = 1'b0;
			end
			foreach (step_words[i])
				expected_words.push_back(step_words[i]);
		endfunction

		function void check_result(logic [7:0] d, logic v, logic l);
			res_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 200)
					$display("%0t: unexpected word, expected none, got %02h/%b/%b",
						$time, d, v, l);
				return;
			end
			want = expected_words.pop_front();
			if (want.data !== d || want.valid !== v || want.last !== l) begin
				errors++;
				if (errors <= 200)
					$display("%0t: mismatch, expected %02h/%b/%b, got %02h/%b/%b",
						$time, want.data, want.valid, want.last, d, v, l);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	strip_scoreboard sb;
	logic [7:0]      text_buf[$];
	int              src_idle  = 8;
	int              sink_idle = 63;
	bit              hold_req  = 1'b0;
	int              hold_left = 0;
	int              words_sent = 0;

	comment_stripper i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// both handshakes sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 80;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_idle);
			end
		end
	end

	// entered and left at a falling edge; valid stays up into the next word
	task automatic send_word(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_buffered();
		foreach (text_buf[i])
			send_word(text_buf[i], i == text_buf.size() - 1);
	endtask

	// biased towards the bytes that steer the scanner
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return CH_SLASH;
		else if (r < 24)
			return CH_STAR;
		else if (r < 31)
			return CH_QUOTE;
		else if (r < 37)
			return CH_BACKSLASH;
		else if (r < 45)
			return CH_NEWLINE;
		return 8'($urandom_range(0, 255));
	endfunction

	// comments and strings with random bodies, mixed with loose noise
	task automatic build_random_text();
		int n;
		int k;
		text_buf.delete();
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
		repeat (n) begin
			k = $urandom_range(0, 6);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (k + 1)
						text_buf.push_back(8'($urandom_range(0, 255)));
				end
				3: begin
					text_buf.push_back(CH_SLASH);
					text_buf.push_back(CH_STAR);
					repeat (k)
						text_buf.push_back(text_char());
					text_buf.push_back(CH_STAR);
					text_buf.push_back(CH_SLASH);
				end
				4: begin
					text_buf.push_back(CH_SLASH);
					text_buf.push_back(CH_SLASH);
					repeat (k)
						text_buf.push_back(text_char());
					text_buf.push_back(CH_NEWLINE);
				end
				5, 6: begin
					text_buf.push_back(CH_QUOTE);
					repeat (k)
						text_buf.push_back(text_char());
					text_buf.push_back(CH_QUOTE);
				end
				default: begin
					text_buf.push_back(text_char());
				end
			endcase
		end
	endtask

	task automatic random_texts(input int n_words);
		int start;
		start = words_sent;
		while (words_sent - start < n_words) begin
			build_random_text();
			send_buffered();
		end
	endtask

	// sender pauses until every predicted word has come out or the wait times out
	task automatic wait_for_results();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10)
			@(negedge clk);
		if (sb.expected_words.size() != 0) begin
			sb.errors += sb.expected_words.size();
			$display("%0t: %0d expected words never arrived", $time, sb.expected_words.size());
			sb.expected_words.delete();
		end
	endtask

	initial begin
		sb       = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// sender mostly busy, receiver mostly stalled
		src_idle  = 8;
		sink_idle = 63;

		// held slash released by a zero byte, then a slash on the final byte goes straight out
		text_buf = '{CH_SLASH, 8'h00, CH_SLASH};
		send_buffered();
		// block opener ending the text
		text_buf = '{CH_SLASH, CH_STAR};
		send_buffered();
		// line opener ending the text
		text_buf = '{CH_SLASH, CH_SLASH};
		send_buffered();
		// line comment up to its newline, block comment keeping its newline with a
		// false close, then a string with an escaped quote and a trailing backslash
		text_buf = '{CH_SLASH, CH_SLASH, 8'h78, CH_NEWLINE, CH_SLASH, CH_STAR, CH_NEWLINE,
			CH_STAR, CH_STAR, 8'h79, CH_STAR, CH_SLASH, CH_QUOTE, CH_BACKSLASH, CH_QUOTE,
			CH_BACKSLASH};
		send_buffered();
		// unclosed block comment, its final byte goes out raw
		text_buf = '{CH_SLASH, CH_STAR, 8'hff};
		send_buffered();
		// block comment closed on the final byte
		text_buf = '{CH_SLASH, CH_STAR, CH_STAR, CH_SLASH};
		send_buffered();

		random_texts(250);
		wait_for_results();

		// sender sparse, receiver mostly ready
		src_idle  = 63;
		sink_idle = 8;
		random_texts(250);
		wait_for_results();

		// no idling, but one long receiver hold-off so the result queue fills
		src_idle  = 0;
		sink_idle = 0;
		hold_req  = 1'b1;
		random_texts(250);
		wait_for_results();

		if (sb.errors == 0)
			$display("comment_stripper verification clean");
		else
			$display("comment_stripper verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("comment_stripper verification failed");
		$finish;
	end

endmodule
